FILE: sv/wifps_pkg.sv
// ----------------------------------------------------------------------------
// wifps_pkg
// Shared types, codes and constants of the weighted idle-first peer selector.
// ----------------------------------------------------------------------------
package wifps_pkg;

  localparam int MAX_PEERS_DEF = 8;
  localparam int DOWN_BITS     = 8;
  localparam int KIND_W        = 3;
  localparam int IDX_W         = 3;
  localparam int REG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_SELECT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESPONSE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WEIGHT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_PEER_COUNT  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DOWN_MASK   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONN_LIMIT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FAIL_LIMIT  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FAIL_WINDOW = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REFRESH_GAP = 3'd5;

  typedef struct packed {
    logic [15:0]        open_conns;
    logic [7:0]         fail_count;
    logic [31:0]        last_access;
    logic [31:0]        last_check;
    logic [31:0]        req_count;
    logic [31:0]        resp_count;
    logic signed [31:0] peer_weight;
  } peer_entry_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SELECT_MULTI,
    OP_SELECT_SINGLE,
    OP_READ,
    OP_MODIFY
  } op_t;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan_issue;
    logic rd_en;
    logic wr_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic req_seen;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/wifps_req_if.sv
// ----------------------------------------------------------------------------
// wifps_req_if
// Request channel: event kind, addressed peer, time, failure flag and weight.
// ----------------------------------------------------------------------------
interface wifps_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [2:0]         peer_index;
  logic [31:0]        now_seconds;
  logic               failed;
  logic signed [31:0] new_weight;

  modport source (output valid, kind, peer_index, now_seconds, failed, new_weight,
                  input ready);
  modport sink (input valid, kind, peer_index, now_seconds, failed, new_weight,
                output ready);
endinterface

FILE: sv/wifps_rsp_if.sv
// ----------------------------------------------------------------------------
// wifps_rsp_if
// Result channel: selected peer, refresh flag and counter readback.
// ----------------------------------------------------------------------------
interface wifps_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  chosen_peer;
  logic        chosen_valid;
  logic        refresh_due;
  logic [31:0] request_total;
  logic [31:0] response_total;

  modport source (output valid, chosen_peer, chosen_valid, refresh_due, request_total,
                  response_total, input ready);
  modport sink (input valid, chosen_peer, chosen_valid, refresh_due, request_total,
                response_total, output ready);
endinterface

FILE: sv/wifps_cfg_if.sv
// ----------------------------------------------------------------------------
// wifps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wifps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [15:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: sv/wifps_ctrl.sv
// ----------------------------------------------------------------------------
// wifps_ctrl
// Sequencer: dispatches a request, runs the peer scan and the table update.
// ----------------------------------------------------------------------------
module wifps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  wifps_pkg::sts_t   sts,
  output wifps_pkg::cmd_t   cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_SCAN     = 7'b0000100,
    S_DRAIN    = 7'b0001000,
    S_RD       = 7'b0010000,
    S_WR       = 7'b0100000,
    S_FINISH   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.req_seen) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op)
          wifps_pkg::OP_SELECT_MULTI: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          wifps_pkg::OP_SELECT_SINGLE, wifps_pkg::OP_READ, wifps_pkg::OP_MODIFY: begin
            state_next = S_RD;
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_RD;
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_en  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.out_load = sts.out_free;
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/wifps_dp.sv
// ----------------------------------------------------------------------------
// wifps_dp
// Datapath: configuration, peer table, scan trackers and result register.
// ----------------------------------------------------------------------------
module wifps_dp #(
  parameter int MAX_PEERS = wifps_pkg::MAX_PEERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  wifps_req_if.sink         req,
  wifps_rsp_if.source       rsp,
  wifps_cfg_if.sink         cfg,
  input  wifps_pkg::cmd_t   cmd,
  output wifps_pkg::sts_t   sts
);

  localparam int AW = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
  localparam int NW = $clog2(MAX_PEERS + 1);

  // Configuration registers.
  logic [3:0]  peer_count;
  logic [7:0]  down_mask;
  logic [15:0] conn_limit;
  logic [7:0]  fail_limit;
  logic [15:0] fail_window;
  logic [15:0] refresh_gap;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_count  <= 4'd1;
      down_mask   <= 8'd0;
      conn_limit  <= 16'd0;
      fail_limit  <= 8'd1;
      fail_window <= 16'd10;
      refresh_gap <= 16'd0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        wifps_pkg::REG_PEER_COUNT:  peer_count  <= cfg.wdata[3:0];
        wifps_pkg::REG_DOWN_MASK:   down_mask   <= cfg.wdata[7:0];
        wifps_pkg::REG_CONN_LIMIT:  conn_limit  <= cfg.wdata;
        wifps_pkg::REG_FAIL_LIMIT:  fail_limit  <= cfg.wdata[7:0];
        wifps_pkg::REG_FAIL_WINDOW: fail_window <= cfg.wdata;
        wifps_pkg::REG_REFRESH_GAP: refresh_gap <= cfg.wdata;
        default: ;
      endcase
    end
  end

  // Captured request.
  logic [2:0]  kind_q;
  logic [2:0]  idx_q;
  logic [31:0] now_q;
  logic        failed_q;
  logic [31:0] weight_q;

  assign req.ready = cmd.take;

  always_ff @(posedge clk) begin
    if (cmd.take && req.valid) begin
      kind_q   <= req.kind;
      idx_q    <= req.peer_index;
      now_q    <= req.now_seconds;
      failed_q <= req.failed;
      weight_q <= req.new_weight;
    end
  end

  // Active peer count and request decode.
  logic [NW-1:0] n_active;
  logic          idx_in_use;
  logic          idx_in_table;
  wifps_pkg::op_t op;

  always_comb begin
    if (peer_count == 4'd0) begin
      n_active = NW'(1);
    end else if (32'(peer_count) > MAX_PEERS) begin
      n_active = NW'(MAX_PEERS);
    end else begin
      n_active = NW'(peer_count);
    end
    idx_in_use   = (NW + 1)'(idx_q) < (NW + 1)'(n_active);
    idx_in_table = 32'(idx_q) < MAX_PEERS;
    if (kind_q == wifps_pkg::KIND_SELECT) begin
      op = (n_active == NW'(1)) ? wifps_pkg::OP_SELECT_SINGLE : wifps_pkg::OP_SELECT_MULTI;
    end else if (kind_q == wifps_pkg::KIND_READ) begin
      op = wifps_pkg::OP_READ;
    end else if ((kind_q == wifps_pkg::KIND_RELEASE || kind_q == wifps_pkg::KIND_RESPONSE ||
                  kind_q == wifps_pkg::KIND_WEIGHT) && idx_in_use) begin
      op = wifps_pkg::OP_MODIFY;
    end else begin
      op = wifps_pkg::OP_NONE;
    end
  end

  // Scan pointer and trackers.
  logic [AW-1:0] ptr;
  logic          eval_v;
  logic [AW-1:0] eval_idx;
  logic          found;
  logic          took_idle;
  logic [AW-1:0] idle_idx;
  logic [31:0]   idle_req;
  logic [AW-1:0] w_idx;
  logic signed [31:0] w_val;
  logic [AW-1:0] best;
  logic [15:0]   gap_counter;
  logic [15:0]   gap_next;

  assign best = took_idle ? idle_idx : w_idx;

  // Peer table.
  wifps_pkg::peer_entry_t mem [MAX_PEERS];
  logic [MAX_PEERS-1:0]   ent_valid;
  wifps_pkg::peer_entry_t rd_data;
  wifps_pkg::peer_entry_t wr_data;
  logic [AW-1:0]          addr;
  logic                   wr_go;

  always_comb begin
    if (cmd.scan_issue) begin
      addr = ptr;
    end else if (op == wifps_pkg::OP_SELECT_MULTI) begin
      addr = best;
    end else if (op == wifps_pkg::OP_SELECT_SINGLE) begin
      addr = '0;
    end else begin
      addr = AW'(idx_q);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue || cmd.rd_en) begin
      rd_data <= ent_valid[addr] ? mem[addr] : '0;
    end
    if (wr_go) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
    end else if (wr_go) begin
      ent_valid[addr] <= 1'b1;
    end
  end

  // Eligibility of the entry in rd_data.
  logic signed [32:0] diff;
  logic               recent;
  logic               is_down;
  logic               eligible;

  always_comb begin
    diff     = $signed({1'b0, now_q}) - $signed({1'b0, rd_data.last_check});
    recent   = diff <= $signed({17'd0, fail_window});
    is_down  = (32'(eval_idx) < wifps_pkg::DOWN_BITS) && down_mask[3'(eval_idx)];
    eligible = !is_down &&
               !(fail_limit != 8'd0 && rd_data.fail_count >= fail_limit && recent) &&
               !(conn_limit != 16'd0 && rd_data.open_conns >= conn_limit);
    gap_next = (gap_counter >= refresh_gap) ? 16'd0 : gap_counter + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eval_v      <= 1'b0;
      gap_counter <= 16'd0;
    end else begin
      eval_v <= cmd.scan_issue;
      if (cmd.scan_start) begin
        gap_counter <= gap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ptr       <= '0;
      found     <= 1'b0;
      took_idle <= 1'b0;
    end else begin
      if (cmd.scan_issue) begin
        ptr      <= ptr + AW'(1);
        eval_idx <= ptr;
      end
      if (eval_v && eligible) begin
        if (!found) begin
          found    <= 1'b1;
          idle_idx <= eval_idx;
          idle_req <= rd_data.req_count;
          w_idx    <= eval_idx;
          w_val    <= rd_data.peer_weight;
        end else begin
          if (rd_data.req_count == rd_data.resp_count && rd_data.req_count < idle_req) begin
            took_idle <= 1'b1;
            idle_idx  <= eval_idx;
            idle_req  <= rd_data.req_count;
          end
          if (rd_data.peer_weight > w_val) begin
            w_idx <= eval_idx;
            w_val <= rd_data.peer_weight;
          end
        end
      end
    end
  end

  // Entry update for the write cycle.
  always_comb begin
    wr_data = rd_data;
    wr_go   = 1'b0;
    case (op)
      wifps_pkg::OP_SELECT_MULTI: begin
        wr_go             = cmd.wr_en && found;
        wr_data.req_count = rd_data.req_count + 32'd1;
        if (rd_data.open_conns != 16'hFFFF) begin
          wr_data.open_conns = rd_data.open_conns + 16'd1;
        end
        if (!recent) begin
          wr_data.last_check = now_q;
        end
      end
      wifps_pkg::OP_SELECT_SINGLE: begin
        wr_go = cmd.wr_en;
        if (rd_data.open_conns != 16'hFFFF) begin
          wr_data.open_conns = rd_data.open_conns + 16'd1;
        end
      end
      wifps_pkg::OP_MODIFY: begin
        wr_go = cmd.wr_en;
        if (kind_q == wifps_pkg::KIND_RELEASE) begin
          if (n_active != NW'(1)) begin
            if (failed_q) begin
              if (rd_data.fail_count != 8'hFF) begin
                wr_data.fail_count = rd_data.fail_count + 8'd1;
              end
              wr_data.last_access = now_q;
              wr_data.last_check  = now_q;
            end else if (rd_data.last_access < rd_data.last_check) begin
              wr_data.fail_count = 8'd0;
            end
          end
          if (rd_data.open_conns != 16'd0) begin
            wr_data.open_conns = rd_data.open_conns - 16'd1;
          end
        end else if (kind_q == wifps_pkg::KIND_RESPONSE) begin
          wr_data.resp_count = rd_data.resp_count + 32'd1;
        end else begin
          wr_data.peer_weight = weight_q;
        end
      end
      default: ;
    endcase
  end

  // Result being built and the output register.
  logic [2:0]  res_peer;
  logic        res_valid;
  logic        res_refresh;
  logic [31:0] res_req;
  logic [31:0] res_resp;

  always_ff @(posedge clk) begin
    if (cmd.take && req.valid) begin
      res_peer    <= 3'd0;
      res_valid   <= 1'b0;
      res_refresh <= 1'b0;
      res_req     <= 32'd0;
      res_resp    <= 32'd0;
    end else begin
      if (cmd.scan_start) begin
        res_refresh <= (gap_next == 16'd0);
      end
      if (cmd.wr_en) begin
        if (op == wifps_pkg::OP_SELECT_MULTI && found) begin
          res_peer  <= 3'(best);
          res_valid <= 1'b1;
        end
        if (op == wifps_pkg::OP_SELECT_SINGLE) begin
          res_valid <= 1'b1;
        end
        if (op == wifps_pkg::OP_READ && idx_in_table) begin
          res_req  <= rd_data.req_count;
          res_resp <= rd_data.resp_count;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp.chosen_peer    <= res_peer;
      rsp.chosen_valid   <= res_valid;
      rsp.refresh_due    <= res_refresh;
      rsp.request_total  <= res_req;
      rsp.response_total <= res_resp;
    end
  end

  always_comb begin
    sts.op        = op;
    sts.req_seen  = req.valid;
    sts.scan_last = ((NW + 1)'(ptr) + (NW + 1)'(1)) == (NW + 1)'(n_active);
    sts.out_free  = !rsp.valid || rsp.ready;
  end

endmodule

FILE: sv/weighted_idle_first_peer_selector_unit.sv
// ----------------------------------------------------------------------------
// weighted_idle_first_peer_selector_unit
// Least-requests upstream peer selector with externally written weights.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Moves
//   --------+-----------+-----------------------------------------------------
//   req     | in        | one request: select, release, response, weight, read
//   rsp     | out       | one result per request
//   cfg     | in        | register writes, index and data, always ready
//
// A select over N peers (N above one) scans the table before the result is
// loaded: the peer table has one read port, so the scan reads one entry per
// cycle, then the chosen entry is reread and updated. Every other request
// skips the scan, and one that is ignored skips the table as well. The next
// request can be taken in the cycle after the result is loaded.
// Reset is synchronous; it restores the register defaults and marks every
// table entry as unwritten, so entries read as zero until first written.
// A stalled result sits in the output register; the next request is
// accepted meanwhile, and its own result waits until that register drains.
//
module weighted_idle_first_peer_selector_unit #(
  parameter int MAX_PEERS = wifps_pkg::MAX_PEERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  wifps_req_if.sink   req,
  wifps_rsp_if.source rsp,
  wifps_cfg_if.sink   cfg
);

  // The controller only sequences; every register holding peer data,
  // configuration or results lives in the datapath.
  wifps_pkg::cmd_t cmd;
  wifps_pkg::sts_t sts;

  wifps_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // The datapath holds the peer table, the scan trackers that find the
  // first eligible peer, the best idle peer and the heaviest peer in one
  // pass, the refresh gap counter and the output register.
  wifps_dp #(
    .MAX_PEERS (MAX_PEERS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg),
    .cmd (cmd),
    .sts (sts)
  );

endmodule

FILE: sv/wifps_checker.sv
// ----------------------------------------------------------------------------
// wifps_checker
// Port-level checks of the peer selector, bound to the top level.
// ----------------------------------------------------------------------------
module wifps_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [2:0]  chosen_peer,
  input logic        chosen_valid,
  input logic        refresh_due,
  input logic [31:0] request_total,
  input logic [31:0] response_total
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_peer) &&
    $stable(request_total))
    else $error("result changed while stalled");

  a_no_peer_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !chosen_valid |-> chosen_peer == 3'd0)
    else $error("peer given without a valid selection");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in work");

  a_fields_apart: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (chosen_valid || refresh_due) |->
    request_total == 32'd0 && response_total == 32'd0)
    else $error("select result carries counter readback");

endmodule

bind weighted_idle_first_peer_selector_unit wifps_checker u_wifps_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .chosen_peer    (rsp.chosen_peer),
  .chosen_valid   (rsp.chosen_valid),
  .refresh_due    (rsp.refresh_due),
  .request_total  (rsp.request_total),
  .response_total (rsp.response_total)
);
